// ===== rtl/apq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types and constants of the aging priority queue.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_VIEW = 2'd2;
  localparam logic [1:0] CMD_TICK = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_TICK  = 2'd3;

  localparam logic [1:0] REG_HIGH   = 2'd0;
  localparam logic [1:0] REG_MEDIUM = 2'd1;
  localparam logic [1:0] REG_AGING  = 2'd2;

  localparam logic [7:0]  HIGH_LIMIT_RST     = 8'd3;
  localparam logic [7:0]  MEDIUM_LIMIT_RST   = 8'd10;
  localparam logic [15:0] AGING_INTERVAL_RST = 16'd300;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] item_size;
  } apq_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] seq_id;
    logic [7:0]  size_out;
    logic [1:0]  class_out;
    logic [31:0] wait_ticks;
    logic        last;
  } apq_res_t;

  typedef struct packed {
    logic [7:0]  high_limit;
    logic [7:0]  medium_limit;
    logic [15:0] aging_interval;
  } apq_cfg_t;

  typedef struct packed {
    logic [1:0]  base_class;
    logic [31:0] seq;
    logic [31:0] arrival;
    logic [7:0]  size;
  } apq_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } apq_state_e;

endpackage

// ===== rtl/aging_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_priority_queue_unit
// Bounded priority queue with class aging, scanned by one shared age unit.
// ----------------------------------------------------------------------------
// Push, tick, full and empty answers are registered and come in the cycle after start.
// Pop: one scan over all entries to the result (one age-unit evaluation per
//   entry), then the later entries move down one slot to close the gap; busy meanwhile.
// View: one full scan over all entries per listed entry, up to MAX_RESULTS entries.
// The single memory read port and the single age unit make each scan sequential.
// Reset clears count, time and sequence; entry storage is never cleared.
module aging_priority_queue_unit
  import apq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command port
  input  logic        start,
  output logic        busy,
  input  apq_req_t    req_i,
  output logic        res_valid_o,
  output apq_res_t    res_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IdxW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int KW   = $clog2(MAX_RESULTS + 1);

  apq_cfg_t cfg;

  apq_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer state
  apq_state_e       state_q, state_d;
  logic [1:0]       cmd_q, cmd_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [31:0]      now_q, now_d;
  logic [31:0]      next_seq_q, next_seq_d;
  logic [CntW-1:0]  iss_idx_q, iss_idx_d;   // next slot to read
  logic             ev_v_q, ev_v_d;         // read data valid this cycle
  logic [IdxW-1:0]  ev_idx_q, ev_idx_d;     // slot of the read data
  logic             best_v_q, best_v_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic [1:0]       best_cls_q, best_cls_d;
  logic [31:0]      best_seq_q, best_seq_d;
  logic [7:0]       best_size_q, best_size_d;
  logic [31:0]      best_wait_q, best_wait_d;
  logic [QUEUE_DEPTH-1:0] taken_q, taken_d; // already listed in this view
  logic [KW-1:0]    view_k_q, view_k_d;
  logic             res_valid_q, res_valid_d;
  apq_res_t         res_q, res_d;

  // memory and age unit
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  apq_entry_t       mem_wdata;
  logic [IdxW-1:0]  mem_raddr;
  apq_entry_t       mem_rdata;
  logic [31:0]      elapsed;
  logic [1:0]       cur_cls;
  logic [1:0]       push_cls;

  apq_entry_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign elapsed = now_q - mem_rdata.arrival;

  apq_age_unit u_age (
    .base_i     (mem_rdata.base_class),
    .elapsed_i  (elapsed),
    .interval_i (cfg.aging_interval),
    .class_o    (cur_cls)
  );

  assign push_cls = (req_i.item_size <= cfg.high_limit)   ? 2'd1 :
                    (req_i.item_size <= cfg.medium_limit) ? 2'd2 : 2'd3;

  // scan bookkeeping
  logic            accept;
  logic            issue;
  logic            last_ev;
  logic            better;
  logic [IdxW-1:0] fin_idx;
  logic [1:0]      fin_cls;
  logic [31:0]     fin_seq;
  logic [7:0]      fin_size;
  logic [31:0]     fin_wait;
  logic [KW-1:0]   k_next;
  logic            view_done;
  logic            need_shift;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start & ~busy;
  assign issue   = ((state_q == S_SCAN) || (state_q == S_SHIFT)) && (iss_idx_q < count_q);
  assign last_ev = ev_v_q && ((CntW'(ev_idx_q) + CntW'(1)) == count_q);

  // lower class wins, then lower sequence; exact ties keep the older slot
  assign better = ev_v_q && !taken_q[ev_idx_q] &&
                  (!best_v_q || (cur_cls < best_cls_q) ||
                   ((cur_cls == best_cls_q) && (mem_rdata.seq < best_seq_q)));

  assign fin_idx  = better ? ev_idx_q       : best_idx_q;
  assign fin_cls  = better ? cur_cls        : best_cls_q;
  assign fin_seq  = better ? mem_rdata.seq  : best_seq_q;
  assign fin_size = better ? mem_rdata.size : best_size_q;
  assign fin_wait = better ? elapsed        : best_wait_q;

  assign k_next     = view_k_q + KW'(1);
  assign view_done  = (32'(k_next) == 32'(MAX_RESULTS)) || (32'(k_next) == 32'(count_q));
  assign need_shift = (CntW'(fin_idx) + CntW'(1)) < count_q;

  assign mem_raddr = iss_idx_q[IdxW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && ((req_i.cmd == CMD_POP) || (req_i.cmd == CMD_VIEW)) &&
            (count_q != '0)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_ev) begin
          if (cmd_q == CMD_POP) begin
            state_d = need_shift ? S_SHIFT : S_IDLE;
          end else if (view_done) begin
            state_d = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        if (last_ev) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d       = cmd_q;
    count_d     = count_q;
    now_d       = now_q;
    next_seq_d  = next_seq_q;
    iss_idx_d   = issue ? (iss_idx_q + CntW'(1)) : iss_idx_q;
    ev_v_d      = issue;
    ev_idx_d    = iss_idx_q[IdxW-1:0];
    best_v_d    = best_v_q;
    best_idx_d  = best_idx_q;
    best_cls_d  = best_cls_q;
    best_seq_d  = best_seq_q;
    best_size_d = best_size_q;
    best_wait_d = best_wait_q;
    taken_d     = taken_q;
    view_k_d    = view_k_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = count_q[IdxW-1:0];
    mem_wdata   = mem_rdata;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          res_d       = '0;
          res_d.last  = 1'b1;
          case (req_i.cmd)
            CMD_PUSH: begin
              if (count_q == CntW'(QUEUE_DEPTH)) begin
                res_d.status = STAT_FULL;
              end else begin
                mem_we               = 1'b1;
                mem_wdata.base_class = push_cls;
                mem_wdata.seq        = next_seq_q;
                mem_wdata.arrival    = now_q;
                mem_wdata.size       = req_i.item_size;
                res_d.status         = STAT_OK;
                res_d.seq_id         = next_seq_q;
                res_d.size_out       = req_i.item_size;
                res_d.class_out      = push_cls;
                count_d              = count_q + CntW'(1);
                next_seq_d           = next_seq_q + 32'd1;
              end
            end
            CMD_TICK: begin
              res_d.status = STAT_TICK;
              now_d        = now_q + 32'd1;
            end
            default: begin
              if (count_q == '0) begin
                res_d.status = STAT_EMPTY;
              end else begin
                res_valid_d = 1'b0;
                cmd_d       = req_i.cmd;
                iss_idx_d   = '0;
                best_v_d    = 1'b0;
                taken_d     = '0;
                view_k_d    = '0;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (better) begin
          best_v_d    = 1'b1;
          best_idx_d  = ev_idx_q;
          best_cls_d  = cur_cls;
          best_seq_d  = mem_rdata.seq;
          best_size_d = mem_rdata.size;
          best_wait_d = elapsed;
        end
        if (last_ev) begin
          res_valid_d     = 1'b1;
          res_d.status    = STAT_OK;
          res_d.seq_id    = fin_seq;
          res_d.size_out  = fin_size;
          res_d.class_out = fin_cls;
          res_d.wait_ticks = fin_wait;
          if (cmd_q == CMD_POP) begin
            res_d.last = 1'b1;
            if (need_shift) begin
              iss_idx_d = CntW'(fin_idx) + CntW'(1);
            end else begin
              count_d = count_q - CntW'(1);
            end
          end else begin
            res_d.last       = view_done;
            taken_d[fin_idx] = 1'b1;
            view_k_d         = k_next;
            iss_idx_d        = '0;
            best_v_d         = 1'b0;
          end
        end
      end
      S_SHIFT: begin
        // move each later entry down one slot
        if (ev_v_q) begin
          mem_we    = 1'b1;
          mem_waddr = ev_idx_q - IdxW'(1);
          mem_wdata = mem_rdata;
        end
        if (last_ev) begin
          count_d = count_q - CntW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_PUSH;
      count_q     <= '0;
      now_q       <= 32'd0;
      next_seq_q  <= 32'd1;
      iss_idx_q   <= '0;
      ev_v_q      <= 1'b0;
      best_v_q    <= 1'b0;
      taken_q     <= '0;
      view_k_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      count_q     <= count_d;
      now_q       <= now_d;
      next_seq_q  <= next_seq_d;
      iss_idx_q   <= iss_idx_d;
      ev_v_q      <= ev_v_d;
      best_v_q    <= best_v_d;
      taken_q     <= taken_d;
      view_k_q    <= view_k_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q    <= ev_idx_d;
    best_idx_q  <= best_idx_d;
    best_cls_q  <= best_cls_d;
    best_seq_q  <= best_seq_d;
    best_size_q <= best_size_d;
    best_wait_q <= best_wait_d;
    res_q       <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

  a_shift_only_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (cmd_q == CMD_POP))
    else $error("shift outside a pop");

  a_last_unless_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.last) |-> ((cmd_q == CMD_VIEW) && (state_q == S_SCAN)))
    else $error("non-final result outside a view");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_SCAN) |-> (count_q != '0))
    else $error("scan started on empty queue");
`endif

endmodule

// ===== rtl/apq_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_cfg_regs
// APB-style configuration registers: class limits and aging interval.
// ----------------------------------------------------------------------------
module apq_cfg_regs
  import apq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output apq_cfg_t    cfg_o
);

  apq_cfg_t   cfg_q, cfg_d;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_HIGH:   cfg_d.high_limit     = pwdata[7:0];
        REG_MEDIUM: cfg_d.medium_limit   = pwdata[7:0];
        REG_AGING:  cfg_d.aging_interval = pwdata[15:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HIGH:   prdata = {24'd0, cfg_q.high_limit};
      REG_MEDIUM: prdata = {24'd0, cfg_q.medium_limit};
      REG_AGING:  prdata = {16'd0, cfg_q.aging_interval};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_limit     <= HIGH_LIMIT_RST;
      cfg_q.medium_limit   <= MEDIUM_LIMIT_RST;
      cfg_q.aging_interval <= AGING_INTERVAL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/apq_entry_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_entry_mem
// Entry storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module apq_entry_mem
  import apq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int IdxW = $clog2(QUEUE_DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  apq_entry_t      wdata_i,
  input  logic [IdxW-1:0] raddr_i,
  output apq_entry_t      rdata_o
);

  apq_entry_t mem_q [QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/apq_age_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_age_unit
// Current class of one entry from base class and elapsed ticks.
// ----------------------------------------------------------------------------
module apq_age_unit (
  input  logic [1:0]  base_i,
  input  logic [31:0] elapsed_i,
  input  logic [15:0] interval_i,
  output logic [1:0]  class_o
);

  logic [16:0] div;
  logic [17:0] div2;
  logic        ge1, ge2;
  logic [1:0]  steps;

  // base is at most 3, so only one and two steps matter
  assign div   = (interval_i == 16'd0) ? 17'd1 : {1'b0, interval_i};
  assign div2  = {div, 1'b0};
  assign ge1   = elapsed_i >= {15'd0, div};
  assign ge2   = elapsed_i >= {14'd0, div2};
  assign steps = ge2 ? 2'd2 : (ge1 ? 2'd1 : 2'd0);

  assign class_o = (base_i > steps) ? (base_i - steps) : 2'd1;

endmodule

// ===== verif/apq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_checker
// Watches the command, result and configuration ports of the aging priority
// queue, keeps its own copy of the queue, and compares every result against
// the oldest expected one.
// ----------------------------------------------------------------------------
module apq_checker
  import apq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  apq_req_t    req_i,
  input  logic        res_valid_o,
  input  apq_res_t    res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  localparam int DEPTH = QUEUE_DEPTH_DEF;

  apq_cfg_t    cfg;
  apq_entry_t  slots[DEPTH];
  int unsigned entry_cnt;
  logic [31:0] now_ticks;
  logic [31:0] seq_next;
  apq_res_t    expected_q[$];

  // current class after aging, floored at 1; zero interval acts as 1
  function automatic logic [1:0] aged_class(apq_entry_t e);
    logic [31:0] div;
    logic [31:0] steps;
    div   = (cfg.aging_interval == 16'd0) ? 32'd1 : {16'd0, cfg.aging_interval};
    steps = (now_ticks - e.arrival) / div;
    if (steps >= {30'd0, e.base_class}) return 2'd1;
    return e.base_class - steps[1:0];
  endfunction

  function automatic int best_slot(bit taken[DEPTH]);
    int best;
    logic [1:0] bc;
    logic [1:0] c;
    best = -1;
    bc   = '0;
    for (int i = 0; i < entry_cnt; i++) begin
      if (!taken[i]) begin
        c = aged_class(slots[i]);
        if (best < 0 || c < bc || (c == bc && slots[i].seq < slots[best].seq)) begin
          best = i;
          bc   = c;
        end
      end
    end
    return best;
  endfunction

  function automatic apq_res_t listed(int s, logic lst);
    apq_res_t r;
    r.status     = STAT_OK;
    r.seq_id     = slots[s].seq;
    r.size_out   = slots[s].size;
    r.class_out  = aged_class(slots[s]);
    r.wait_ticks = now_ticks - slots[s].arrival;
    r.last       = lst;
    return r;
  endfunction

  task automatic queue_expected(apq_res_t r);
    expected_q = {expected_q, r};
  endtask

  task automatic predict_request(apq_req_t r);
    apq_res_t   e;
    apq_entry_t ne;
    bit         taken[DEPTH];
    int         s;
    int         total;
    e      = '0;
    e.last = 1'b1;
    taken  = '{default: 1'b0};
    if (r.cmd == CMD_PUSH) begin
      if (entry_cnt >= DEPTH) begin
        e.status = STAT_FULL;
      end else begin
        ne.base_class = (r.item_size <= cfg.high_limit) ? 2'd1 :
                        (r.item_size <= cfg.medium_limit) ? 2'd2 : 2'd3;
        ne.seq        = seq_next;
        ne.arrival    = now_ticks;
        ne.size       = r.item_size;
        slots[entry_cnt] = ne;
        entry_cnt++;
        e.status    = STAT_OK;
        e.seq_id    = seq_next;
        e.size_out  = r.item_size;
        e.class_out = ne.base_class;
        seq_next++;
      end
      queue_expected(e);
    end else if (r.cmd == CMD_TICK) begin
      now_ticks++;
      e.status = STAT_TICK;
      queue_expected(e);
    end else if (entry_cnt == 0) begin
      e.status = STAT_EMPTY;
      queue_expected(e);
    end else if (r.cmd == CMD_POP) begin
      s = best_slot(taken);
      queue_expected(listed(s, 1'b1));
      for (int i = s; i + 1 < entry_cnt; i++) slots[i] = slots[i + 1];
      entry_cnt--;
    end else begin
      total = (entry_cnt < MAX_RESULTS) ? int'(entry_cnt) : MAX_RESULTS;
      for (int k = 0; k < total; k++) begin
        s = best_slot(taken);
        taken[s] = 1'b1;
        queue_expected(listed(s, k + 1 == total));
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    apq_res_t e;
    if (!rst_ni) begin
      cfg        = {HIGH_LIMIT_RST, MEDIUM_LIMIT_RST, AGING_INTERVAL_RST};
      entry_cnt  = 0;
      now_ticks  = '0;
      seq_next   = 32'd1;
      fail_count = 0;
      expected_q.delete();
      pending    = 0;
    end else begin
      // results first: they belong to requests accepted earlier
      if (res_valid_o) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result %p", res_o);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          check_field("status",     32'(e.status),     32'(res_o.status));
          check_field("seq_id",     e.seq_id,          res_o.seq_id);
          check_field("size_out",   32'(e.size_out),   32'(res_o.size_out));
          check_field("class_out",  32'(e.class_out),  32'(res_o.class_out));
          check_field("wait_ticks", e.wait_ticks,      res_o.wait_ticks);
          check_field("last",       32'(e.last),       32'(res_o.last));
        end
      end
      if (start && !busy) predict_request(req_i);
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_HIGH:   cfg.high_limit     = pwdata[7:0];
          REG_MEDIUM: cfg.medium_limit   = pwdata[7:0];
          REG_AGING:  cfg.aging_interval = pwdata[15:0];
          default: ;
        endcase
      end
      pending = expected_q.size();
    end
  end

endmodule

// ===== verif/tb_aging_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aging_priority_queue_unit
// Drives directed and random push/pop/view/tick requests through several
// register settings; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_aging_priority_queue_unit;
  import apq_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  apq_req_t    req_i = '0;
  logic        res_valid_o;
  apq_res_t    res_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          no_gaps = 1'b0;  // burst mode: back-to-back requests

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  aging_priority_queue_unit dut (.*);

  apq_checker chk (.*);

  // hard stop if the run hangs (also catches leftover expectations)
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One request: optional idle gap, then hold start until accepted.
  // start stays high across back-to-back requests.
  task automatic send_request(logic [1:0] c, logic [7:0] s);
    int gap;
    gap = no_gaps ? 0 : int'($urandom_range(0, 14));
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start         = 1'b1;
    req_i.cmd     = c;
    req_i.item_size = s;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Drain: stop issuing, wait for all expected results and for busy to drop
  // (a pop keeps compacting after its result), then a few spare cycles.
  task automatic drain();
    start = 1'b0;
    @(negedge clk_i);
    while (pending != 0 || busy) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // APB write: setup then access phase, completes on pready
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_limits(logic [7:0] hi, logic [7:0] med, logic [15:0] intv);
    drain();
    reg_write(REG_HIGH,   {24'd0, hi});
    reg_write(REG_MEDIUM, {24'd0, med});
    reg_write(REG_AGING,  {16'd0, intv});
  endtask

  // Random mix; push weight varies so the queue both fills and empties.
  task automatic random_phase(int n, int push_pct);
    int roll;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      roll = int'($urandom_range(0, 99));
      if (roll < push_pct)
        send_request(CMD_PUSH, 8'($urandom_range(0, 255)));
      else if (roll < push_pct + 20)
        send_request(CMD_POP, 8'($urandom_range(0, 255)));
      else if (roll < push_pct + 30)
        send_request(CMD_VIEW, 8'($urandom_range(0, 255)));
      else
        send_request(CMD_TICK, 8'($urandom_range(0, 255)));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty answers, tick, class boundaries at reset limits
    send_request(CMD_POP,  8'd0);
    send_request(CMD_VIEW, 8'd0);
    send_request(CMD_TICK, 8'd0);
    send_request(CMD_PUSH, 8'd0);
    send_request(CMD_PUSH, 8'd255);
    send_request(CMD_PUSH, 8'd3);
    send_request(CMD_PUSH, 8'd4);
    send_request(CMD_PUSH, 8'd10);
    send_request(CMD_PUSH, 8'd11);
    send_request(CMD_VIEW, 8'd0);
    // fill to capacity, then one push too many, then a full-length view
    for (int i = 0; i < 10; i++) send_request(CMD_PUSH, 8'hA5 ^ i[7:0]);
    send_request(CMD_PUSH, 8'h5A);
    send_request(CMD_VIEW, 8'hFF);
    send_request(CMD_TICK, 8'hFF);
    send_request(CMD_POP,  8'hFF);

    // random phases over several settings, extremes included;
    // interval 0 behaves as 1, fast intervals make aging visible
    set_limits(8'd0,   8'd255, 16'd1);
    random_phase(90, 40);
    set_limits(8'd255, 8'd0,   16'hFFFF);
    random_phase(70, 30);
    set_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd0);
    random_phase(90, 45);
    set_limits(8'($urandom_range(0, 128)), 8'($urandom_range(64, 255)),
               16'($urandom_range(1, 6)));
    random_phase(110, 35);
    set_limits(HIGH_LIMIT_RST, MEDIUM_LIMIT_RST, 16'($urandom_range(2, 4)));
    random_phase(80, 40);

    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== aging_priority_queue_unit.f =====
rtl/apq_pkg.sv
rtl/apq_cfg_regs.sv
rtl/apq_entry_mem.sv
rtl/apq_age_unit.sv
rtl/aging_priority_queue_unit.sv
verif/apq_checker.sv
verif/tb_aging_priority_queue_unit.sv
